@@ src/ddo_pkg.sv @@
// Shared types, constants and the arctangent table of the odometry block.
// Used by every module of the block; depends on nothing.
package ddo_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int CORDIC_STEPS_DEF = 24;

    localparam int CW        = 34;
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 27;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    localparam logic [19:0] WHEEL_BASE_RST = 20'd190000;
    localparam logic [15:0] GAIN_RST       = 16'd16384;

    localparam int          DIST_CHUNKS  = 3;
    localparam logic [4:0]  DIST_DIVISOR = 5'd25;
    localparam logic [21:0] DIST_RECIP   = 22'd2684355;

    localparam logic signed [CW-1:0] PI_Q         = CW'(843314857);
    localparam logic signed [CW-1:0] TWO_PI_Q     = CW'(1686629713);
    localparam logic signed [CW-1:0] HALF_PI_Q    = CW'(421657428);
    localparam logic signed [CW-1:0] TWO_PI_FOLD  = CW'(1686630973);
    localparam logic signed [CW-1:0] CORDIC_START = CW'(652032874);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WHEEL_BASE   = 3'd0,
        REG_LIN_FORWARD  = 3'd1,
        REG_LIN_REVERSE  = 3'd2,
        REG_TURN_LEFT    = 3'd3,
        REG_TURN_RIGHT   = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVH_START,
        ST_DIVH_RUN,
        ST_SCALE,
        ST_DIST_INIT,
        ST_DIST_RUN,
        ST_CORDIC,
        ST_MUL_X,
        ST_MUL_Y,
        ST_UPD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       div_start;
        logic       dist_init;
        logic       dist_step;
        logic       scale;
        logic       step_ld;
        logic       dist_ld;
        logic       cordic_step;
        logic [4:0] iter;
        logic       mul_x;
        logic       mul_y;
        logic       upd;
        logic       out_ld;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic signed [CW-1:0] atan_q28(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:    v = CW'(210828714);
            5'd1:    v = CW'(124459457);
            5'd2:    v = CW'(65760959);
            5'd3:    v = CW'(33381290);
            5'd4:    v = CW'(16755422);
            5'd5:    v = CW'(8385879);
            5'd6:    v = CW'(4193963);
            5'd7:    v = CW'(2097109);
            5'd8:    v = CW'(1048571);
            5'd9:    v = CW'(524287);
            5'd10:   v = CW'(262144);
            5'd11:   v = CW'(131072);
            5'd12:   v = CW'(65536);
            5'd13:   v = CW'(32768);
            5'd14:   v = CW'(16384);
            5'd15:   v = CW'(8192);
            5'd16:   v = CW'(4096);
            5'd17:   v = CW'(2048);
            5'd18:   v = CW'(1024);
            5'd19:   v = CW'(512);
            5'd20:   v = CW'(256);
            5'd21:   v = CW'(128);
            5'd22:   v = CW'(64);
            5'd23:   v = CW'(32);
            5'd24:   v = CW'(16);
            5'd25:   v = CW'(8);
            5'd26:   v = CW'(4);
            5'd27:   v = CW'(2);
            5'd28:   v = CW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ src/ddo_if.sv @@
// Valid/ready channel interfaces for wheel samples and pose results.
// Depends on nothing.
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic        [19:0] interval;

    modport source (output valid, left_speed, right_speed, interval, input ready);
    modport sink   (input valid, left_speed, right_speed, interval, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [31:0] heading;
    logic signed [15:0] forward_speed;
    logic signed [31:0] heading_step;
    logic               standing;

    modport source (output valid, pos_x, pos_y, heading, forward_speed, heading_step,
                    standing, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, forward_speed, heading_step,
                    standing, output ready);
endinterface

@@ src/ddo_div.sv @@
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on ddo_pkg.
module ddo_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ddo_pkg::DIV_NUM_W-1:0]  num,
    input  logic [ddo_pkg::DIV_DEN_W-1:0]  den,
    output logic [ddo_pkg::DIV_NUM_W-1:0]  quot,
    output logic                           done
);
    import ddo_pkg::*;

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] q_reg, q_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;

    always_comb
    begin
        trial     = {rem_reg, q_reg[DIV_NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            q_next    = {q_reg[DIV_NUM_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            busy_next = cnt_reg != DIV_CNT_W'(DIV_NUM_W - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = q_reg;
    assign done = !busy_reg;

endmodule

@@ src/ddo_ctrl.sv @@
// Controller state machine that sequences the odometry datapath.
// Depends on ddo_pkg.
module ddo_ctrl #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ddo_pkg::status_t status,
    output ddo_pkg::cmd_t    cmd
);
    import ddo_pkg::*;

    localparam int ROT_N = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam int IW    = $clog2(ROT_N);

    state_t        state_reg, state_next;
    logic [IW-1:0] it_reg, it_next;

    always_comb
    begin
        state_next = state_reg;
        it_next    = '0;
        case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_PREP;
            ST_PREP:       state_next = ST_DIVH_START;
            ST_DIVH_START: state_next = ST_DIVH_RUN;
            ST_DIVH_RUN:   if (status.div_done) state_next = ST_SCALE;
            ST_SCALE:      state_next = ST_DIST_INIT;
            ST_DIST_INIT:  state_next = ST_DIST_RUN;
            ST_DIST_RUN:
            begin
                it_next = it_reg + 1'b1;
                if (it_reg == IW'(DIST_CHUNKS - 1))
                begin
                    state_next = ST_CORDIC;
                    it_next    = '0;
                end
            end
            ST_CORDIC:
            begin
                it_next = it_reg + 1'b1;
                if (it_reg == IW'(ROT_N - 1))
                begin
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X:      state_next = ST_MUL_Y;
            ST_MUL_Y:      state_next = ST_UPD;
            ST_UPD:        state_next = ST_DONE;
            ST_DONE:       if (status.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.iter = 5'(it_reg);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PREP:       cmd.prep = 1'b1;
            ST_DIVH_START: cmd.div_start = 1'b1;
            ST_DIVH_RUN:   cmd.scale = 1'b0;
            ST_SCALE:      cmd.scale = 1'b1;
            ST_DIST_INIT:
            begin
                cmd.dist_init = 1'b1;
                cmd.step_ld   = 1'b1;
            end
            ST_DIST_RUN:   cmd.dist_step = 1'b1;
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                cmd.dist_ld     = 1'b1;
            end
            ST_MUL_X:      cmd.mul_x = 1'b1;
            ST_MUL_Y:      cmd.mul_y = 1'b1;
            ST_UPD:        cmd.upd = 1'b1;
            ST_DONE:       cmd.out_ld = status.out_free;
            default:       cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            it_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            it_reg    <= it_next;
        end
    end

endmodule

@@ src/ddo_datapath.sv @@
// Datapath: configuration registers, pose state, scaling, CORDIC and output register.
// Depends on ddo_pkg and ddo_div.
module ddo_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data,
    input  ddo_pkg::cmd_t                  cmd,
    output ddo_pkg::status_t               status,
    input  logic signed [15:0]             left_speed,
    input  logic signed [15:0]             right_speed,
    input  logic        [19:0]             interval,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic signed [47:0]             pos_x,
    output logic signed [47:0]             pos_y,
    output logic signed [31:0]             heading,
    output logic signed [15:0]             forward_speed,
    output logic signed [31:0]             heading_step,
    output logic                           standing
);
    import ddo_pkg::*;

    logic [19:0] wheel_base_reg;
    logic [15:0] lin_fwd_reg, lin_rev_reg, turn_left_reg, turn_right_reg;

    logic signed [47:0] x_store_reg, y_store_reg;
    logic signed [31:0] heading_store_reg;
    logic               out_valid_reg;

    logic signed [15:0] l_reg, r_reg;
    logic        [19:0] dt_reg;
    logic        [35:0] nh_reg, nd_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic               diff_pos_reg, diff_neg_reg, sum_pos_reg, sum_neg_reg;
    logic signed [15:0] fwd_reg;
    logic               stand_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    logic        [49:0] mh_reg;
    logic        [42:0] numd_reg;
    logic        [47:0] dn_reg, dq_reg;
    logic        [4:0]  drem_reg;
    logic signed [31:0] step_reg;
    logic signed [39:0] dist_reg;
    logic signed [65:0] prod_reg;

    logic signed [47:0] px_reg, py_reg;
    logic signed [31:0] ph_reg, ps_reg;
    logic signed [15:0] pf_reg;
    logic               pst_reg;

    logic signed [16:0] diff, sum, sum_half;
    logic        [15:0] diff_abs;
    logic        [16:0] sum_abs;
    logic        [19:0] wb_eff;
    logic signed [CW-1:0] z0, z1;
    logic               flip0;
    logic [DIV_NUM_W-1:0] div_num, quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic               div_done;
    logic        [47:0] raw_sat;
    logic        [63:0] mh_prod;
    logic        [51:0] nd_prod;
    logic        [20:0] dv;
    logic        [41:0] drp;
    logic        [15:0] dq_chunk;
    logic        [4:0]  drem_next;
    logic        [31:0] step_mag;
    logic signed [39:0] dist_mag;
    logic signed [CW-1:0] xs, ys, atan_v, c_full, s_full;
    logic signed [25:0] c8, s8;
    logic signed [65:0] rnd_sum;
    logic signed [35:0] rnd;
    logic signed [CW-1:0] h0, h1, h2;
    logic signed [31:0] h_sat;

    always_comb
    begin
        diff     = 17'(r_reg) - 17'(l_reg);
        sum      = 17'(l_reg) + 17'(r_reg);
        diff_abs = diff[16] ? 16'(-diff) : diff[15:0];
        sum_abs  = sum[16] ? 17'(-sum) : sum;
        sum_half = (sum + 17'(sum[16])) >>> 1;
        wb_eff   = (wheel_base_reg == '0) ? 20'd1 : wheel_base_reg;

        z0    = CW'(heading_store_reg);
        if (z0 > PI_Q)
        begin
            z0 = z0 - TWO_PI_Q;
        end
        else if (z0 < -PI_Q)
        begin
            z0 = z0 + TWO_PI_Q;
        end
        flip0 = 1'b0;
        z1    = z0;
        if (z0 > HALF_PI_Q)
        begin
            z1    = z0 - PI_Q;
            flip0 = 1'b1;
        end
        else if (z0 < -HALF_PI_Q)
        begin
            z1    = z0 + PI_Q;
            flip0 = 1'b1;
        end
    end

    assign div_num = {nh_reg, 28'd0};
    assign div_den = den_reg;

    ddo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .done  (div_done)
    );

    always_comb
    begin
        raw_sat  = (quot > 64'h8000_0000_0000) ? 48'h8000_0000_0000 : quot[47:0];
        mh_prod  = 64'(raw_sat) * 64'(diff_pos_reg ? turn_left_reg : turn_right_reg);
        nd_prod  = 52'(nd_reg) * 52'(sum_pos_reg ? lin_fwd_reg : lin_rev_reg);
        step_mag = (mh_reg > 50'h8000_0000) ? 32'h8000_0000 : mh_reg[31:0];

        // Division by 25, sixteen dividend bits per step, by reciprocal multiplication.
        dv        = {drem_reg, dn_reg[47:32]};
        drp       = 42'(dv) * 42'(DIST_RECIP);
        dq_chunk  = drp[41:26];
        drem_next = 5'(dv - 21'(dq_chunk) * 21'(DIST_DIVISOR));
        dist_mag  = {1'b0, dq_reg[38:0]};

        atan_v = atan_q28(cmd.iter);
        xs     = x_reg >>> cmd.iter;
        ys     = y_reg >>> cmd.iter;

        c_full = flip_reg ? -x_reg : x_reg;
        s_full = flip_reg ? -y_reg : y_reg;
        c8     = c_full[CW-1:8];
        s8     = s_full[CW-1:8];

        rnd_sum = prod_reg + 66'sd536870912;
        rnd     = rnd_sum[65:30];

        h0 = CW'(heading_store_reg) + CW'(step_reg);
        h1 = (h0 >= TWO_PI_FOLD) ? h0 - TWO_PI_FOLD : h0;
        h2 = (h1 <= -TWO_PI_FOLD) ? h1 + TWO_PI_FOLD : h1;
        if (h2 > CW'(64'sd2147483647))
        begin
            h_sat = 32'sh7FFF_FFFF;
        end
        else if (h2 < -CW'(64'sd2147483648))
        begin
            h_sat = 32'sh8000_0000;
        end
        else
        begin
            h_sat = h2[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_base_reg    <= WHEEL_BASE_RST;
            lin_fwd_reg       <= GAIN_RST;
            lin_rev_reg       <= GAIN_RST;
            turn_left_reg     <= GAIN_RST;
            turn_right_reg    <= GAIN_RST;
            x_store_reg       <= '0;
            y_store_reg       <= '0;
            heading_store_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WHEEL_BASE:  wheel_base_reg <= cfg_data;
                    REG_LIN_FORWARD: lin_fwd_reg    <= cfg_data[15:0];
                    REG_LIN_REVERSE: lin_rev_reg    <= cfg_data[15:0];
                    REG_TURN_LEFT:   turn_left_reg  <= cfg_data[15:0];
                    REG_TURN_RIGHT:  turn_right_reg <= cfg_data[15:0];
                    default:         wheel_base_reg <= wheel_base_reg;
                endcase
            end
            if (cmd.mul_y)
            begin
                x_store_reg <= x_store_reg + 48'(rnd);
            end
            if (cmd.upd)
            begin
                y_store_reg       <= y_store_reg + 48'(rnd);
                heading_store_reg <= h_sat;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            l_reg  <= left_speed;
            r_reg  <= right_speed;
            dt_reg <= interval;
        end
        if (cmd.prep)
        begin
            nh_reg       <= 36'(diff_abs) * 36'(dt_reg);
            nd_reg       <= 36'(sum_abs) * 36'(dt_reg);
            den_reg      <= DIV_DEN_W'(wb_eff) * DIV_DEN_W'(100);
            diff_pos_reg <= !diff[16] && (diff != '0);
            diff_neg_reg <= diff[16];
            sum_pos_reg  <= !sum[16] && (sum != '0);
            sum_neg_reg  <= sum[16];
            fwd_reg      <= (dt_reg == '0) ? 16'sd0 : sum_half[15:0];
            stand_reg    <= (l_reg == '0) && (r_reg == '0);
            x_reg        <= CORDIC_START;
            y_reg        <= '0;
            z_reg        <= z1;
            flip_reg     <= flip0;
        end
        if (cmd.scale)
        begin
            mh_reg   <= mh_prod[63:14];
            numd_reg <= nd_prod[51:9];
        end
        if (cmd.step_ld)
        begin
            if (diff_pos_reg)
            begin
                step_reg <= (mh_reg > 50'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mh_reg[31:0];
            end
            else if (diff_neg_reg)
            begin
                step_reg <= -step_mag;
            end
            else
            begin
                step_reg <= '0;
            end
        end
        if (cmd.dist_init)
        begin
            dn_reg   <= 48'(numd_reg);
            dq_reg   <= '0;
            drem_reg <= '0;
        end
        if (cmd.dist_step)
        begin
            dn_reg   <= {dn_reg[31:0], 16'd0};
            dq_reg   <= {dq_reg[31:0], dq_chunk};
            drem_reg <= drem_next;
        end
        if (cmd.dist_ld)
        begin
            dist_reg <= sum_neg_reg ? -dist_mag : dist_mag;
        end
        if (cmd.cordic_step)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_v;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_v;
            end
        end
        if (cmd.mul_x)
        begin
            prod_reg <= 66'(dist_reg) * 66'(c8);
        end
        if (cmd.mul_y)
        begin
            prod_reg <= 66'(dist_reg) * 66'(s8);
        end
        if (cmd.out_ld)
        begin
            px_reg  <= x_store_reg;
            py_reg  <= y_store_reg;
            ph_reg  <= heading_store_reg;
            pf_reg  <= fwd_reg;
            ps_reg  <= step_reg;
            pst_reg <= stand_reg;
        end
    end

    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid     = out_valid_reg;
    assign pos_x         = px_reg;
    assign pos_y         = py_reg;
    assign heading       = ph_reg;
    assign forward_speed = pf_reg;
    assign heading_step  = ps_reg;
    assign standing      = pst_reg;

endmodule

@@ src/differential_drive_odometry_unit.sv @@
// Top level of the differential-drive odometry block.
// Depends on ddo_pkg, ddo_if, ddo_ctrl and ddo_datapath.
//
//   Port       Direction  Carries
//   in_ch      sink       left_speed, right_speed, interval
//   out_ch     source     pos_x, pos_y, heading, forward_speed, heading_step, standing
//   cfg_*      write      wheel_base and the four gains, by index 0 to 4
//
// A new transaction is taken only after the previous one has finished. The time between them
// is set by the bit-serial divider for the heading change, which runs 64 steps,
// by the distance division in three reciprocal steps, and by the CORDIC,
// which rotates once per cycle.
// Reset is asynchronous and active low; configuration returns to its default values.
// A finished result waits in the output register while the next transaction is taken;
// a stalled output adds the cycles until that register is free.
module differential_drive_odometry_unit #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ddo_pkg::CFG_DATA_W-1:0] cfg_data,
    ddo_in_if.sink                         in_ch,
    ddo_out_if.source                      out_ch
);
    import ddo_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    ddo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ddo_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status),
        .left_speed    (in_ch.left_speed),
        .right_speed   (in_ch.right_speed),
        .interval      (in_ch.interval),
        .out_ready     (out_ch.ready),
        .out_valid     (out_ch.valid),
        .pos_x         (out_ch.pos_x),
        .pos_y         (out_ch.pos_y),
        .heading       (out_ch.heading),
        .forward_speed (out_ch.forward_speed),
        .heading_step  (out_ch.heading_step),
        .standing      (out_ch.standing)
    );

    assign in_ch.ready = in_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ready |=> !in_ready)
        else $error("input taken again before the transaction finished");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_ld |-> !out_ch.valid || out_ch.ready)
        else $error("pending result overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !status.div_done)
        else $error("divider did not start");

endmodule

@@ tb/tb_differential_drive_odometry_unit.sv @@
// Self-checking testbench of the differential-drive odometry unit.
// Depends on ddo_pkg, ddo_if and the unit itself.
// A scoreboard predicts each pose, and random traffic with stalls runs under several settings.
module tb_differential_drive_odometry_unit;
    import ddo_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = CORDIC_STEPS_DEF;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam longint FOLD = 64'sd1686630973;
    localparam longint PI_EXACT = 64'sd843314857;
    localparam longint TWO_PI_EXACT = 64'sd1686629713;
    localparam longint HALF_PI_EXACT = 64'sd421657428;
    localparam longint ROT_START = 64'sd652032874;

    typedef struct {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [31:0] heading;
        logic signed [15:0] forward_speed;
        logic signed [31:0] heading_step;
        logic               standing;
    } pose_t;

    class pose_scoreboard;
        logic [19:0] wheel_base;
        logic [15:0] lin_fwd, lin_rev, turn_left, turn_right;
        logic [47:0] x_acc, y_acc;
        longint      heading_acc;
        longint      arctan[32];
        pose_t       pending_poses[$];
        int          errors;

        function new();
            longint tbl[32] = '{210828714, 124459457, 65760959, 33381290, 16755422,
                8385879, 4193963, 2097109, 1048571, 524287, 262144, 131072, 65536,
                32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
                8, 4, 2, 1, 0, 0, 0};
            arctan = tbl;
            wheel_base = WHEEL_BASE_RST;
            lin_fwd = GAIN_RST;
            lin_rev = GAIN_RST;
            turn_left = GAIN_RST;
            turn_right = GAIN_RST;
            x_acc = '0;
            y_acc = '0;
            heading_acc = 0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [19:0] val);
            case (idx)
                REG_WHEEL_BASE:  wheel_base = val;
                REG_LIN_FORWARD: lin_fwd = val[15:0];
                REG_LIN_REVERSE: lin_rev = val[15:0];
                REG_TURN_LEFT:   turn_left = val[15:0];
                REG_TURN_RIGHT:  turn_right = val[15:0];
                default: ;
            endcase
        endfunction

        function void rotate(longint ang, output longint c, output longint s);
            longint x, y, z, t;
            bit flip;
            x = ROT_START;
            y = 0;
            z = ang;
            flip = 0;
            while (z > PI_EXACT) z -= TWO_PI_EXACT;
            while (z < -PI_EXACT) z += TWO_PI_EXACT;
            if (z > HALF_PI_EXACT) begin
                z -= PI_EXACT;
                flip = 1;
            end
            else if (z < -HALF_PI_EXACT) begin
                z += PI_EXACT;
                flip = 1;
            end
            for (int i = 0; i < STEPS && i < 32; i++) begin
                if (z >= 0) begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= arctan[i];
                end
                else begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += arctan[i];
                end
                x = t;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function void note_sample(logic signed [15:0] l, logic signed [15:0] r, logic [19:0] dt);
            longint diff, sum, step, travel, c, s, h;
            longint unsigned n, q1, r1, raw, m, gain, den;
            pose_t p;
            diff = longint'(r) - longint'(l);
            sum = longint'(l) + longint'(r);
            den = (wheel_base == 0) ? 64'd100 : 64'(wheel_base) * 64'd100;
            n = longint'(diff < 0 ? -diff : diff) * 64'(dt);
            q1 = n / den;
            r1 = n % den;
            raw = (q1 << 28) + ((r1 << 28) / den);
            if (raw > (64'd1 << 47)) raw = 64'd1 << 47;
            gain = diff > 0 ? 64'(turn_left) : 64'(turn_right);
            m = (raw * gain) >> 14;
            step = 0;
            if (diff > 0) begin
                if (m > 64'h7FFFFFFF) m = 64'h7FFFFFFF;
                step = longint'(m);
            end
            else if (diff < 0) begin
                if (m > 64'h80000000) m = 64'h80000000;
                step = -longint'(m);
            end
            n = longint'(sum < 0 ? -sum : sum) * 64'(dt);
            gain = sum > 0 ? 64'(lin_fwd) : 64'(lin_rev);
            m = (n * gain) / 64'd12800;
            travel = sum < 0 ? -longint'(m) : longint'(m);
            rotate(heading_acc, c, s);
            x_acc = x_acc + 48'((travel * (c >>> 8) + (64'sd1 << 29)) >>> 30);
            y_acc = y_acc + 48'((travel * (s >>> 8) + (64'sd1 << 29)) >>> 30);
            h = heading_acc + step;
            if (h >= FOLD) h -= FOLD;
            if (h <= -FOLD) h += FOLD;
            if (h > 64'sd2147483647) h = 64'sd2147483647;
            if (h < -64'sd2147483648) h = -64'sd2147483648;
            heading_acc = h;
            p.pos_x = x_acc;
            p.pos_y = y_acc;
            p.heading = 32'(h);
            p.forward_speed = (dt == 0) ? 16'sd0 : 16'(sum / 2);
            p.heading_step = 32'(step);
            p.standing = (l == 0 && r == 0);
            pending_poses.push_back(p);
        endfunction

        function void check_pose(pose_t got);
            pose_t e;
            if (pending_poses.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending_poses.pop_front();
            if (got.pos_x !== e.pos_x) begin
                $error("pos_x expected %0d actual %0d", e.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== e.pos_y) begin
                $error("pos_y expected %0d actual %0d", e.pos_y, got.pos_y);
                errors++;
            end
            if (got.heading !== e.heading) begin
                $error("heading expected %0d actual %0d", e.heading, got.heading);
                errors++;
            end
            if (got.forward_speed !== e.forward_speed) begin
                $error("forward_speed expected %0d actual %0d", e.forward_speed,
                    got.forward_speed);
                errors++;
            end
            if (got.heading_step !== e.heading_step) begin
                $error("heading_step expected %0d actual %0d", e.heading_step,
                    got.heading_step);
                errors++;
            end
            if (got.standing !== e.standing) begin
                $error("standing expected %0b actual %0b", e.standing, got.standing);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int idle_cycles;
    int stall_period, stall_duty, stall_count, stall_phase;
    int burst_left;
    pose_scoreboard odo_board;

    ddo_in_if in_ch();
    ddo_out_if out_ch();

    differential_drive_odometry_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        pose_t got;
        if (out_ch.valid && out_ch.ready) begin
            got.pos_x = out_ch.pos_x;
            got.pos_y = out_ch.pos_y;
            got.heading = out_ch.heading;
            got.forward_speed = out_ch.forward_speed;
            got.heading_step = out_ch.heading_step;
            got.standing = out_ch.standing;
            odo_board.check_pose(got);
        end
        if (stall_count == 0) begin
            stall_period = $urandom_range(1, 16);
            stall_duty = ($urandom_range(0, 3) == 0) ? stall_period
                                                      : $urandom_range(1, stall_period);
            stall_count = $urandom_range(50, 600);
        end
        else begin
            stall_count--;
        end
        stall_phase = (stall_phase + 1) % stall_period;
        out_ch.ready <= rst_n && (stall_phase < stall_duty);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        odo_board.set_register(idx, val);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [19:0] wb, logic [15:0] lf, logic [15:0] lr,
                           logic [15:0] tl, logic [15:0] tr);
        write_reg(REG_WHEEL_BASE, wb);
        write_reg(REG_LIN_FORWARD, lf);
        write_reg(REG_LIN_REVERSE, lr);
        write_reg(REG_TURN_LEFT, tl);
        write_reg(REG_TURN_RIGHT, tr);
    endtask

    task automatic send_sample(logic signed [15:0] l, logic signed [15:0] r, logic [19:0] dt);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.left_speed <= l;
        in_ch.right_speed <= r;
        in_ch.interval <= dt;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        odo_board.note_sample(l, r, dt);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = $urandom_range(0, 200);
        end
        else begin
            burst_left--;
            gap = 0;
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (odo_board.pending_poses.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_directed();
        send_sample(16'sd32767, 16'sd32767, 20'hFFFFF);
        send_sample(-16'sd32768, -16'sd32768, 20'hFFFFF);
        send_sample(-16'sd32768, 16'sd32767, 20'hFFFFF);
        send_sample(16'sd32767, -16'sd32768, 20'hFFFFF);
        send_sample(-16'sd32768, 16'sd32767, 20'hFFFFF);
        send_sample(16'sd0, 16'sd0, 20'd5000);
        send_sample(16'sd0, 16'sd0, 20'd0);
        send_sample(16'sd300, -16'sd700, 20'd0);
        send_sample(-16'sd1, 16'sd0, 20'd1);
        send_sample(16'sd1, 16'sd0, 20'd1);
        send_sample(-16'sd3, 16'sd2, 20'd77777);
        send_sample(16'sd1000, 16'sd1000, 20'd100000);
        send_sample(-16'sd500, 16'sd500, 20'd400000);
        send_sample(16'sd500, -16'sd500, 20'd400000);
        send_sample(16'sd1200, 16'sd900, 20'd20000);
        send_sample(-16'sd800, -16'sd1100, 20'd50000);
        send_sample(16'sd32767, 16'sd32767, 20'hFFFFF);
        send_sample(16'sd1, -16'sd1, 20'h80000);
    endtask

    task automatic send_random(int count);
        logic signed [15:0] l, r;
        logic [19:0] dt;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0: begin
                    l = 16'($urandom);
                    r = 16'($urandom);
                    dt = 20'($urandom);
                end
                1: begin
                    l = 16'($urandom_range(0, 6000) - 3000);
                    r = l;
                    dt = 20'($urandom_range(0, 200000));
                end
                2: begin
                    l = 16'($urandom_range(0, 6000) - 3000);
                    r = -l;
                    dt = 20'($urandom_range(0, 500000));
                end
                3: begin
                    l = 0;
                    r = 0;
                    dt = 20'($urandom);
                end
                4: begin
                    l = 16'($urandom);
                    r = 16'($urandom);
                    dt = 0;
                end
                5: begin
                    l = 16'($urandom_range(0, 40) - 20);
                    r = 16'($urandom_range(0, 40) - 20);
                    dt = 20'($urandom_range(0, 20000));
                end
                default: begin
                    l = 16'($urandom_range(0, 6000) - 3000);
                    r = 16'($urandom_range(0, 6000) - 3000);
                    dt = 20'($urandom_range(0, 100000));
                end
            endcase
            send_sample(l, r, dt);
        end
    endtask

    initial begin
        odo_board = new();
        idle_cycles = 0;
        stall_period = 1;
        stall_duty = 1;
        stall_count = 0;
        stall_phase = 0;
        burst_left = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.left_speed <= '0;
        in_ch.right_speed <= '0;
        in_ch.interval <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        send_random(300);
        drain();

        write_reg(REG_SPARE, 20'hFFFFF);
        set_all(20'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_directed();
        send_random(300);
        drain();

        set_all(20'hFFFFF, 16'd0, 16'd0, 16'd0, 16'd0);
        send_directed();
        send_random(250);
        drain();

        set_all(20'd1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_random(250);
        drain();

        set_all(20'd1, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        send_random(250);
        drain();

        repeat (2) begin
            set_all(20'($urandom_range(1, 1048575)), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom));
            send_random(220);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (odo_board.errors == 0 && odo_board.pending_poses.size() == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/ddo_pkg.sv
src/ddo_if.sv
src/ddo_div.sv
src/ddo_ctrl.sv
src/ddo_datapath.sv
src/differential_drive_odometry_unit.sv
tb/tb_differential_drive_odometry_unit.sv
